// File: src/outstanding_task_timeout_tracker_top_assert.svh
// Assertion macros for the outstanding task tracker.
// Included by the modules that check their own logic; needs clk and rst_n in scope.
`ifndef OUTSTANDING_TASK_TIMEOUT_TRACKER_TOP_ASSERT_SVH
`define OUTSTANDING_TASK_TIMEOUT_TRACKER_TOP_ASSERT_SVH

// Condition and consequence in the same cycle.
`define OTTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequence in the cycle after the condition.
`define OTTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ottt_pkg.sv
// Shared types and constants for the outstanding task tracker.
// No dependencies; imported by every module of the block.
package ottt_pkg;

  localparam int MAX_SLOTS_DEF  = 16;
  localparam int ID_WIDTH_DEF   = 16;
  localparam int TIME_WIDTH_DEF = 32;

  localparam int SLOT_LIMIT_W = 5;
  localparam int TIMEOUT_W    = 32;
  localparam int FREE_W       = 5;
  localparam int OP_W         = 2;
  localparam int CFG_IDX_W    = 1;

  localparam logic [SLOT_LIMIT_W-1:0] SLOT_LIMIT_RST = 5'd16;
  localparam logic [TIMEOUT_W-1:0]    TIMEOUT_RST    = 32'd60000;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_ADMIT = 2'd0,
    OP_DONE  = 2'd1,
    OP_SWEEP = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOID  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_EMIT
  } state_t;

  // Per-cycle command to the row of cells.
  typedef struct packed {
    logic shift;  // every cell takes its upper neighbour
    logic push;   // selected cell loads the write data
  } chain_ctl_t;

endpackage

// File: src/ottt_cell.sv
// One slot of the task list: id and start tick.
// Depends on ottt_pkg for the chain command struct.
module ottt_cell
  import ottt_pkg::*;
#(
  parameter int ID_W   = ID_WIDTH_DEF,
  parameter int TIME_W = TIME_WIDTH_DEF
) (
  input  logic              clk,
  input  chain_ctl_t        ctl,
  input  logic              sel,
  input  logic [ID_W-1:0]   nb_id,
  input  logic [TIME_W-1:0] nb_start,
  input  logic [ID_W-1:0]   wr_id,
  input  logic [TIME_W-1:0] wr_start,
  output logic [ID_W-1:0]   id,
  output logic [TIME_W-1:0] start
);

  logic [ID_W-1:0]   id_r,    id_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;

  // a push to this cell wins over the shift
  always_comb begin
    id_nxt    = id_r;
    start_nxt = start_r;
    if (ctl.push && sel) begin
      id_nxt    = wr_id;
      start_nxt = wr_start;
    end else if (ctl.shift) begin
      id_nxt    = nb_id;
      start_nxt = nb_start;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    start_r <= start_nxt;
  end

  assign id    = id_r;
  assign start = start_r;

endmodule

// File: src/ottt_chain.sv
// Row of task slots; cell 0 is the oldest entry and the only one read out.
// Depends on ottt_pkg and ottt_cell.
module ottt_chain
  import ottt_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int ID_W      = ID_WIDTH_DEF,
  parameter int TIME_W    = TIME_WIDTH_DEF,
  parameter int CW        = $clog2(MAX_SLOTS + 1)
) (
  input  logic              clk,
  input  chain_ctl_t        ctl,
  input  logic [CW-1:0]     wr_pos,
  input  logic [ID_W-1:0]   wr_id,
  input  logic [TIME_W-1:0] wr_start,
  output logic [ID_W-1:0]   head_id,
  output logic [TIME_W-1:0] head_start
);

  logic [ID_W-1:0]   id_q    [MAX_SLOTS];
  logic [TIME_W-1:0] start_q [MAX_SLOTS];

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    logic [ID_W-1:0]   nb_id;
    logic [TIME_W-1:0] nb_start;

    if (i == MAX_SLOTS - 1) begin : g_top
      // nothing above the top cell; what it takes on a shift is never read
      assign nb_id    = wr_id;
      assign nb_start = wr_start;
    end else begin : g_mid
      assign nb_id    = id_q[i+1];
      assign nb_start = start_q[i+1];
    end

    ottt_cell #(
      .ID_W   (ID_W),
      .TIME_W (TIME_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .sel      (wr_pos == CW'(i)),
      .nb_id    (nb_id),
      .nb_start (nb_start),
      .wr_id    (wr_id),
      .wr_start (wr_start),
      .id       (id_q[i]),
      .start    (start_q[i])
    );
  end

  assign head_id    = id_q[0];
  assign head_start = start_q[0];

endmodule

// File: src/ottt_cancel_q.sv
// Buffer of ids cancelled by a sweep, read back in order with registered data.
// Depends on ottt_pkg for default widths.
module ottt_cancel_q
  import ottt_pkg::*;
#(
  parameter int DEPTH = MAX_SLOTS_DEF,
  parameter int ID_W  = ID_WIDTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  logic [ID_W-1:0] wdata,
  input  logic [AW-1:0]   raddr,
  output logic [ID_W-1:0] rdata
);

  logic [ID_W-1:0] mem [DEPTH];
  logic [ID_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/outstanding_task_timeout_tracker_top.sv
// Outstanding task tracker with stale-task timeout: control, sweep and result stage.
// Depends on ottt_pkg, ottt_chain (ottt_cell), ottt_cancel_q and the assertion header.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tuser: op; tdata: task_id, now_ms
//  out_    | out | out_tvalid / out_tready| tuser: cancel_valid; tdata: status,
//          |     |                        | cancel_id, free_slots; tlast: last
//  cfg_    | in  | cfg_we                 | cfg_idx, cfg_data
//
// Admit, no-op, and complete or sweep on an empty list: the result is loaded from the emit
// state that follows the transaction. Complete and sweep rotate the whole list through
// cell 0, one entry a cycle, then emit a plain result or the cancels; the registered buffer
// read keeps a cancel from being emitted straight after the one before it.
// Synchronous active-low reset empties the list and loads the register defaults.
// A new transaction is taken whenever the sequencer is idle, even while the last result
// still waits in the output register; a stalled output only holds the emit phase.
module outstanding_task_timeout_tracker_top
  import ottt_pkg::*;
#(
  parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
  parameter int ID_WIDTH   = ID_WIDTH_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  localparam int IN_DW     = ((ID_WIDTH + TIME_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW    = ((ID_WIDTH + 2 + FREE_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DW-1:0]      in_tdata,   // task_id, now_ms, zero pad
  input  logic [OP_W-1:0]       in_tuser,   // op

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DW-1:0]     out_tdata,  // status, cancel_id, free_slots, zero pad
  output logic [0:0]            out_tuser,  // cancel_valid
  output logic                  out_tlast,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [TIMEOUT_W-1:0]  cfg_data
);

  localparam int CW   = $clog2(MAX_SLOTS + 1);
  localparam int AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LW   = (CW > SLOT_LIMIT_W) ? CW : SLOT_LIMIT_W;
  localparam int CMPW = (TIME_WIDTH > TIMEOUT_W) ? TIME_WIDTH : TIMEOUT_W;

  // configuration
  logic [SLOT_LIMIT_W-1:0] slot_lim_r;
  logic [TIMEOUT_W-1:0]    timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_lim_r <= SLOT_LIMIT_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SLOT_LIMIT: slot_lim_r <= cfg_data[SLOT_LIMIT_W-1:0];
        CFG_TIMEOUT:    timeout_r  <= cfg_data;
        default:        ;
      endcase
    end
  end

  // sequencer state
  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r,   cnt_nxt;
  logic [CW-1:0]       walk_r,  walk_nxt;   // entries still to inspect
  logic [CW-1:0]       wq_r,    wq_nxt;     // ids cancelled so far
  logic [CW-1:0]       rd_r,    rd_nxt;     // next cancel to emit
  logic                found_r, found_nxt;
  logic                q_ok_r,  q_ok_nxt;   // buffer data matches rd_r
  status_t             res_st_r, res_st_nxt;
  op_t                 op_r,    op_nxt;
  logic [ID_WIDTH-1:0] tid_r,   tid_nxt;
  logic [TIME_WIDTH-1:0] now_r, now_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  status_t             out_st_r,    out_st_nxt;
  logic                out_cv_r,    out_cv_nxt;
  logic [ID_WIDTH-1:0] out_id_r,    out_id_nxt;
  logic [FREE_W-1:0]   out_free_r,  out_free_nxt;
  logic                out_last_r,  out_last_nxt;

  // list and buffer wiring
  chain_ctl_t            ctl;
  logic [CW-1:0]         wr_pos;
  logic [ID_WIDTH-1:0]   wr_id;
  logic [TIME_WIDTH-1:0] wr_start;
  logic [ID_WIDTH-1:0]   head_id;
  logic [TIME_WIDTH-1:0] head_start;
  logic                  q_we;
  logic [ID_WIDTH-1:0]   q_rdata;

  // effective limit and free count
  logic [LW-1:0]         lim;
  logic [LW-1:0]         cnt_ext;
  logic [LW-1:0]         free_w;
  logic                  admit_full;
  logic [TIME_WIDTH-1:0] age;
  logic                  stale;
  logic                  drop;
  logic                  in_fire;
  logic                  out_load;
  logic                  emit_last;
  op_t                   in_op;
  logic [ID_WIDTH-1:0]   in_id;
  logic [TIME_WIDTH-1:0] in_now;

  assign in_op  = op_t'(in_tuser);
  assign in_id  = in_tdata[ID_WIDTH-1:0];
  assign in_now = in_tdata[ID_WIDTH+TIME_WIDTH-1:ID_WIDTH];

  assign lim = (LW'(slot_lim_r) > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : LW'(slot_lim_r);
  assign cnt_ext = LW'(cnt_r);
  assign free_w  = (cnt_ext >= lim) ? '0 : lim - cnt_ext;
  assign admit_full = (in_op == OP_ADMIT) && (cnt_ext >= lim);

  // head-of-list age check, wrapped at the tick width
  assign age   = now_r - head_start;
  assign stale = CMPW'(age) >= CMPW'(timeout_r);
  assign drop  = (op_r == OP_SWEEP) ? stale : (!found_r && (head_id == tid_r));

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = !out_valid_r || out_tready;
  assign emit_last = (rd_r == wq_r - CW'(1));

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    walk_nxt   = walk_r;
    wq_nxt     = wq_r;
    rd_nxt     = rd_r;
    found_nxt  = found_r;
    res_st_nxt = res_st_r;
    op_nxt     = op_r;
    tid_nxt    = tid_r;
    now_nxt    = now_r;
    q_ok_nxt   = 1'b0;

    ctl.shift  = 1'b0;
    ctl.push   = 1'b0;
    wr_pos     = cnt_r;
    wr_id      = in_id;
    wr_start   = in_now;
    q_we       = 1'b0;

    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt    = out_st_r;
    out_cv_nxt    = out_cv_r;
    out_id_nxt    = out_id_r;
    out_free_nxt  = out_free_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_op;
          tid_nxt    = in_id;
          now_nxt    = in_now;
          wq_nxt     = '0;
          rd_nxt     = '0;
          found_nxt  = 1'b0;
          res_st_nxt = ST_OK;
          walk_nxt   = cnt_r;
          state_nxt  = S_EMIT;
          case (in_op)
            OP_ADMIT: begin
              if (cnt_ext < lim) begin
                ctl.push = 1'b1;
                cnt_nxt  = cnt_r + CW'(1);
              end else begin
                res_st_nxt = ST_FULL;
              end
            end
            OP_DONE: begin
              if (cnt_r == '0) begin
                res_st_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_WALK;
              end
            end
            OP_SWEEP: begin
              if (cnt_r != '0) begin
                state_nxt = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end

      S_WALK: begin
        // pop the head; kept entries go back in at the tail
        ctl.shift = 1'b1;
        ctl.push  = !drop;
        wr_pos    = cnt_r - CW'(1);
        wr_id     = head_id;
        wr_start  = head_start;
        walk_nxt  = walk_r - CW'(1);
        if (drop) begin
          cnt_nxt = cnt_r - CW'(1);
          if (op_r == OP_SWEEP) begin
            q_we   = 1'b1;
            wq_nxt = wq_r + CW'(1);
          end else begin
            found_nxt = 1'b1;
          end
        end
        if (walk_r == CW'(1)) begin
          state_nxt = S_EMIT;
          if (op_r == OP_DONE && !(found_r || drop)) begin
            res_st_nxt = ST_NOID;
          end
        end
      end

      S_EMIT: begin
        q_ok_nxt = 1'b1;
        if (wq_r == '0) begin
          if (out_load) begin
            out_valid_nxt = 1'b1;
            out_st_nxt    = res_st_r;
            out_cv_nxt    = 1'b0;
            out_id_nxt    = '0;
            out_free_nxt  = free_w[FREE_W-1:0];
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (out_load && q_ok_r) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = ST_OK;
          out_cv_nxt    = 1'b1;
          out_id_nxt    = q_rdata;
          out_free_nxt  = free_w[FREE_W-1:0];
          out_last_nxt  = emit_last;
          rd_nxt        = rd_r + CW'(1);
          q_ok_nxt      = 1'b0;   // read data is registered behind the pointer
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      walk_r      <= '0;
      wq_r        <= '0;
      rd_r        <= '0;
      found_r     <= 1'b0;
      q_ok_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      walk_r      <= walk_nxt;
      wq_r        <= wq_nxt;
      rd_r        <= rd_nxt;
      found_r     <= found_nxt;
      q_ok_r      <= q_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    res_st_r   <= res_st_nxt;
    op_r       <= op_nxt;
    tid_r      <= tid_nxt;
    now_r      <= now_nxt;
    out_st_r   <= out_st_nxt;
    out_cv_r   <= out_cv_nxt;
    out_id_r   <= out_id_nxt;
    out_free_r <= out_free_nxt;
    out_last_r <= out_last_nxt;
  end

  ottt_chain #(
    .MAX_SLOTS (MAX_SLOTS),
    .ID_W      (ID_WIDTH),
    .TIME_W    (TIME_WIDTH),
    .CW        (CW)
  ) u_chain (
    .clk        (clk),
    .ctl        (ctl),
    .wr_pos     (wr_pos),
    .wr_id      (wr_id),
    .wr_start   (wr_start),
    .head_id    (head_id),
    .head_start (head_start)
  );

  ottt_cancel_q #(
    .DEPTH (MAX_SLOTS),
    .ID_W  (ID_WIDTH),
    .AW    (AW)
  ) u_cancel_q (
    .clk   (clk),
    .we    (q_we),
    .waddr (wq_r[AW-1:0]),
    .wdata (head_id),
    .raddr (rd_r[AW-1:0]),
    .rdata (q_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_free_r, out_id_r, out_st_r});
  assign out_tuser  = out_cv_r;
  assign out_tlast  = out_last_r;

  // checks on the sequencer
  `include "outstanding_task_timeout_tracker_top_assert.svh"

  `OTTT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_SLOTS), "list count above slot total")
  `OTTT_ASSERT_NOW(a_walk_live, state_r == S_WALK, walk_r != '0 && walk_r <= cnt_r, "walk count off")
  `OTTT_ASSERT_NOW(a_emit_ptr, state_r == S_EMIT && wq_r != '0, rd_r < wq_r, "read past fill")
  `OTTT_ASSERT_NEXT(a_full_hold, in_fire && admit_full, $stable(cnt_r), "full admit moved count")
  `OTTT_ASSERT_NOW(a_cancel_ok, out_valid_r && out_cv_r, out_st_r == ST_OK, "cancel with error")

endmodule

// File: bench/outstanding_task_timeout_tracker_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for outstanding_task_timeout_tracker_top: directed table, random phases.
// Depends on ottt_pkg and the tracker RTL; results are checked against an in-bench tracker model.
module outstanding_task_timeout_tracker_top_tb
  import ottt_pkg::*;
();

  localparam int SLOTS       = MAX_SLOTS_DEF;
  localparam int IN_DW       = 48;      // task_id [15:0], now_ms [47:16]
  localparam int OUT_DW      = 24;      // status [1:0], cancel_id [17:2], free_slots [22:18]
  localparam int CYCLE_LIMIT = 400000;  // watchdog bound, far above the slowest legal run
  localparam int MAX_REPORTS = 10;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 42;
  localparam int DRAIN_WAIT  = 40;      // full-list walk plus output register, with margin

  // One result transaction, field for field
  typedef struct packed {
    status_t           status;
    logic              cancel_valid;
    logic [15:0]       cancel_id;
    logic [FREE_W-1:0] free_slots;
    logic              last;
  } result_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_LIMIT,
    ROW_TIMEOUT
  } row_kind_t;

  // Directed stimulus row; value is now_ms for items, register data for writes.
  // Where typed is set the single result is taken from st/free, not from the model.
  typedef struct {
    row_kind_t         kind;
    op_t               op;
    logic [15:0]       id;
    logic [31:0]       value;
    bit                typed;
    status_t           st;
    logic [FREE_W-1:0] free;
  } row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic [IN_DW-1:0]     in_tdata   = '0;
  logic [OP_W-1:0]      in_tuser   = '0;   // op
  logic                 out_tready = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx    = '0;
  logic [TIMEOUT_W-1:0] cfg_data   = '0;
  logic                 in_tready;
  logic                 out_tvalid;
  logic [OUT_DW-1:0]    out_tdata;         // status, cancel_id, free_slots, zero pad
  logic [0:0]           out_tuser;         // cancel_valid
  logic                 out_tlast;

  always #2 clk = ~clk;

  outstanding_task_timeout_tracker_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Tracker model: ordered list of (id, start tick), plus its own register copies
  // ---------------------------------------------------------------------------
  logic [15:0]             held_id    [SLOTS];
  logic [31:0]             held_start [SLOTS];
  int                      held_count;
  logic [SLOT_LIMIT_W-1:0] limit_reg;
  logic [TIMEOUT_W-1:0]    timeout_reg;

  // Expected results, oldest first
  result_t pending_results[$];

  // Directed stimulus table
  row_t dir_rows[$];

  int bad_results   = 0;
  int cycles        = 0;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int stall_left    = 0;
  result_t seen_res;
  result_t want_res;

  // Append one expected result at the tail
  function automatic void queue_result(result_t res);
    pending_results.insert(pending_results.size(), res);
  endfunction

  // Append one row to the directed table
  function automatic void add_row(row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Limit saturates at the slot count; free count saturates at zero
  function automatic int free_slots_now();
    int lim;
    lim = (limit_reg > SLOTS) ? SLOTS : int'(limit_reg);
    return (held_count >= lim) ? 0 : lim - held_count;
  endfunction

  // Close the gap so the list stays in admission order
  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_id[i]    = held_id[i + 1];
      held_start[i] = held_start[i + 1];
    end
    held_count--;
  endfunction

  // Applies one transaction to the model; queues its results when keep is set
  function automatic void track_txn(op_t op, logic [15:0] id, logic [31:0] now, bit keep);
    int                pos;
    logic [31:0]       age;
    status_t           st;
    result_t           res;
    logic [15:0]       gone_ids[$];
    logic [FREE_W-1:0] free5;
    st = ST_OK;
    case (op)
      OP_ADMIT: begin
        if (free_slots_now() > 0) begin
          held_id[held_count]    = id;
          held_start[held_count] = now;
          held_count++;
        end else begin
          st = ST_FULL;
        end
      end
      OP_DONE: begin
        if (held_count == 0) begin
          st = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < held_count && held_id[pos] != id) pos++;
          if (pos < held_count) drop_entry(pos);
          else st = ST_NOID;
        end
      end
      OP_SWEEP: begin
        pos = 0;
        while (pos < held_count && gone_ids.size() < SLOTS) begin
          age = now - held_start[pos];   // wraps mod 2^32
          if (age >= timeout_reg) begin
            gone_ids.insert(gone_ids.size(), held_id[pos]);
            drop_entry(pos);
          end else begin
            pos++;
          end
        end
      end
      default: ;   // unused op: one plain result
    endcase
    if (!keep) return;
    free5 = FREE_W'(free_slots_now());   // count after the whole step
    if (gone_ids.size() == 0) begin
      res = '{st, 1'b0, 16'h0, free5, 1'b1};
      queue_result(res);
    end else begin
      for (int k = 0; k < gone_ids.size(); k++) begin
        res = '{ST_OK, 1'b1, gone_ids[k], free5, (k == gone_ids.size() - 1)};
        queue_result(res);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Everything moves with NBAs at the rising edge; handshakes are
  // judged on the values held just before the edge.
  // ---------------------------------------------------------------------------

  // One input transaction, with an optional idle burst ahead of it.
  // tvalid is only lowered by an idle burst or a register write, so it is
  // never dropped and raised in the same step.
  task automatic send_txn(op_t op, logic [15:0] id, logic [31:0] now, bit typed,
                          result_t fixed);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {now, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_txn(op, id, now, !typed);
    if (typed) queue_result(fixed);
  endtask

  // Register write, only once the block has drained every expected result
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIMEOUT_W-1:0] val);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SLOT_LIMIT) limit_reg = val[SLOT_LIMIT_W-1:0];
    else timeout_reg = val;
    @(posedge clk);
  endtask

  // Result-side back-pressure: bursts of stalled cycles, started at random per out_stall_pct
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      stall_left <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_res = '{status_t'(out_tdata[1:0]), out_tuser[0], out_tdata[17:2],
                   out_tdata[22:18], out_tlast};
      if (pending_results.size() == 0) begin
        if (bad_results < MAX_REPORTS)
          $display("%0t: unexpected result st=%0d cv=%0b id=%h free=%0d last=%0b", $realtime,
                   seen_res.status, seen_res.cancel_valid, seen_res.cancel_id,
                   seen_res.free_slots, seen_res.last);
        bad_results++;
      end else begin
        want_res = pending_results.pop_front();
        if (seen_res != want_res) begin
          if (bad_results < MAX_REPORTS) begin
            $display("%0t: mismatch exp st=%0d cv=%0b id=%h free=%0d last=%0b",
                     $realtime, want_res.status, want_res.cancel_valid, want_res.cancel_id,
                     want_res.free_slots, want_res.last);
            $display("    got st=%0d cv=%0b id=%h free=%0d last=%0b", seen_res.status,
                     seen_res.cancel_valid, seen_res.cancel_id, seen_res.free_slots,
                     seen_res.last);
          end
          bad_results++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    result_t     fixed_res;
    op_t         op;
    logic [15:0] id;
    logic [15:0] id_pool [6];
    logic [31:0] tick;
    logic [31:0] tmo;
    logic [31:0] step_max;
    int          lim;
    int          roll;
    int          shift;
    int          admit_pct;

    held_count  = 0;
    limit_reg   = SLOT_LIMIT_RST;
    timeout_reg = TIMEOUT_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults are limit 16, timeout 60000
    // complete / sweep / no-op on an empty list
    add_row('{ROW_ITEM, OP_DONE,  16'h0005, 32'd0,        1'b1, ST_EMPTY, 5'd16});
    add_row('{ROW_ITEM, OP_SWEEP, 16'h0000, 32'd100,      1'b1, ST_OK,    5'd16});
    add_row('{ROW_ITEM, OP_NOP,   16'h0007, 32'd0,        1'b1, ST_OK,    5'd16});
    // field extremes on admit
    add_row('{ROW_ITEM, OP_ADMIT, 16'h0000, 32'd0,        1'b1, ST_OK,    5'd15});
    add_row('{ROW_ITEM, OP_ADMIT, 16'hFFFF, 32'hFFFFFFFF, 1'b1, ST_OK,    5'd14});
    // unknown id
    add_row('{ROW_ITEM, OP_DONE,  16'h1234, 32'd0,        1'b1, ST_NOID,  5'd14});
    // ages 59999 and exactly 60000 across the wrap: only the second goes
    add_row('{ROW_ITEM, OP_SWEEP, 16'h0000, 32'd59999,    1'b0, ST_OK,    5'd0});
    add_row('{ROW_ITEM, OP_DONE,  16'h0000, 32'd0,        1'b0, ST_OK,    5'd0});
    // limit of one, then of zero: full
    add_row('{ROW_LIMIT, OP_NOP,  16'h0000, 32'd1,        1'b0, ST_OK,    5'd0});
    add_row('{ROW_ITEM, OP_ADMIT, 16'hAAAA, 32'd10,       1'b1, ST_OK,    5'd0});
    add_row('{ROW_ITEM, OP_ADMIT, 16'h5555, 32'd20,       1'b1, ST_FULL,  5'd0});
    add_row('{ROW_LIMIT, OP_NOP,  16'h0000, 32'd0,        1'b0, ST_OK,    5'd0});
    add_row('{ROW_ITEM, OP_ADMIT, 16'h0001, 32'd30,       1'b1, ST_FULL,  5'd0});
    // limit above the slot count saturates at 16
    add_row('{ROW_LIMIT, OP_NOP,  16'h0000, 32'd31,       1'b0, ST_OK,    5'd0});
    add_row('{ROW_ITEM, OP_ADMIT, 16'h0002, 32'd40,       1'b1, ST_OK,    5'd14});
    // zero timeout: everything is stale, even at age zero
    add_row('{ROW_TIMEOUT, OP_NOP, 16'h0000, 32'd0,       1'b0, ST_OK,    5'd0});
    add_row('{ROW_ITEM, OP_SWEEP, 16'h0000, 32'd40,       1'b0, ST_OK,    5'd0});
    // largest timeout: only a full wrap of age qualifies
    add_row('{ROW_TIMEOUT, OP_NOP, 16'h0000, 32'hFFFFFFFF, 1'b0, ST_OK,   5'd0});
    add_row('{ROW_ITEM, OP_ADMIT, 16'h0003, 32'd100,      1'b1, ST_OK,    5'd15});
    add_row('{ROW_ITEM, OP_SWEEP, 16'h0000, 32'd99,       1'b0, ST_OK,    5'd0});
    add_row('{ROW_ITEM, OP_ADMIT, 16'h0004, 32'd500,      1'b1, ST_OK,    5'd15});
    add_row('{ROW_ITEM, OP_SWEEP, 16'h0000, 32'd600,      1'b1, ST_OK,    5'd15});
    add_row('{ROW_ITEM, OP_DONE,  16'h0004, 32'd0,        1'b1, ST_OK,    5'd16});
    add_row('{ROW_ITEM, OP_NOP,   16'hFFFF, 32'hFFFFFFFF, 1'b1, ST_OK,    5'd16});

    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        ROW_LIMIT:   write_reg(CFG_SLOT_LIMIT, dir_rows[r].value);
        ROW_TIMEOUT: write_reg(CFG_TIMEOUT, dir_rows[r].value);
        default: begin
          fixed_res = '{dir_rows[r].st, 1'b0, 16'h0, dir_rows[r].free, 1'b1};
          send_txn(dir_rows[r].op, dir_rows[r].id, dir_rows[r].value, dir_rows[r].typed,
                   fixed_res);
        end
      endcase
    end

    // Random phases, each under its own register setting. The list carries over
    // between phases, so a lowered limit meets a fuller list (free count clamps).
    tick = $urandom;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin lim = 16;                     tmo = 32'd60000;                 end
        1:       begin lim = 31;                     tmo = $urandom;                  end
        2:       begin lim = 3;                      tmo = $urandom_range(1, 300);    end
        3:       begin lim = 0;                      tmo = 32'd0;                     end
        4:       begin lim = 1;                      tmo = 32'hFFFFFFFF;              end
        5:       begin lim = $urandom_range(0, 31);  tmo = $urandom_range(1, 5000);   end
        default: begin lim = 16;                     tmo = 32'd60000;                 end
      endcase
      write_reg(CFG_SLOT_LIMIT, lim);
      write_reg(CFG_TIMEOUT, tmo);

      // last phase runs flat out on both sides
      if (ph == PHASES - 1) begin
        in_idle_pct   <= 0;
        out_stall_pct <= 0;
      end else begin
        in_idle_pct   <= 20 * $urandom_range(0, 2);
        out_stall_pct <= 20 * $urandom_range(0, 2);
      end

      // small id pool so duplicates and oldest-match completions happen
      foreach (id_pool[p]) id_pool[p] = 16'($urandom);
      shift     = $urandom_range(1, 5);
      admit_pct = $urandom_range(35, 65);
      step_max  = (timeout_reg >> shift) + 1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // time mostly creeps forward against the timeout, now and then jumps anywhere
        if ($urandom_range(0, 99) < 12) tick = $urandom;
        else tick = tick + $urandom_range(0, step_max);

        roll = $urandom_range(0, 99);
        if (roll < admit_pct)           op = OP_ADMIT;
        else if (roll < admit_pct + 22) op = OP_DONE;
        else if (roll < 96)             op = OP_SWEEP;
        else                            op = OP_NOP;

        if (op == OP_DONE && held_count > 0 && $urandom_range(0, 3) != 0)
          id = held_id[$urandom_range(0, held_count - 1)];
        else if ($urandom_range(0, 6) == 0)
          id = 16'($urandom);
        else
          id = id_pool[$urandom_range(0, 5)];

        send_txn(op, id, tick, 1'b0, '0);
      end
    end

    // Drain, then allow for a late or stray result
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (bad_results == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/ottt_pkg.sv
src/ottt_cell.sv
src/ottt_chain.sv
src/ottt_cancel_q.sv
src/outstanding_task_timeout_tracker_top.sv
bench/outstanding_task_timeout_tracker_top_tb.sv
